>>> rtl/core/elementwise_reduction_alu_unit_defines.svh
// ============================================================================
// Element-wise reduction ALU: assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ============================================================================
`ifndef ELEMENTWISE_REDUCTION_ALU_UNIT_DEFINES_SVH
`define ELEMENTWISE_REDUCTION_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define ERAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define ERAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/erau_pkg.sv
// ============================================================================
// Element-wise reduction ALU package
// Operator and element type codes and the configuration bundle.
// ============================================================================
package erau_pkg;

    // Reduction operator codes.
    localparam logic [3:0] OP_SUM     = 4'd0;
    localparam logic [3:0] OP_PROD    = 4'd1;
    localparam logic [3:0] OP_MAX     = 4'd2;
    localparam logic [3:0] OP_MIN     = 4'd3;
    localparam logic [3:0] OP_LAND    = 4'd4;
    localparam logic [3:0] OP_BAND    = 4'd5;
    localparam logic [3:0] OP_LOR     = 4'd6;
    localparam logic [3:0] OP_BOR     = 4'd7;
    localparam logic [3:0] OP_LXOR    = 4'd8;
    localparam logic [3:0] OP_BXOR    = 4'd9;
    localparam logic [3:0] OP_MAXLOC  = 4'd10;
    localparam logic [3:0] OP_MINLOC  = 4'd11;
    localparam logic [3:0] OP_REPLACE = 4'd12;

    // Element type codes.
    localparam logic [3:0] TY_S8  = 4'd0;
    localparam logic [3:0] TY_S16 = 4'd1;
    localparam logic [3:0] TY_S32 = 4'd2;
    localparam logic [3:0] TY_S64 = 4'd3;
    localparam logic [3:0] TY_U8  = 4'd4;
    localparam logic [3:0] TY_U16 = 4'd5;
    localparam logic [3:0] TY_U32 = 4'd6;
    localparam logic [3:0] TY_U64 = 4'd7;
    localparam logic [3:0] TY_RAW = 4'd8;

    // Register indexes on the configuration port.
    localparam logic REG_OPERATION    = 1'b0;
    localparam logic REG_ELEMENT_TYPE = 1'b1;

    // Configuration handed from the register block to the datapath.
    typedef struct packed {
        logic [3:0] op;
        logic [3:0] ty;
    } cfg_t;

endpackage

>>> rtl/core/erau_alu.sv
// ============================================================================
// Element-wise reduction ALU datapath
// Combines one registered destination and source element under the
// configured operator and type, using precomputed partial products of the 32-bit operand halves.
// ============================================================================
module erau_alu (
    input  erau_pkg::cfg_t      cfg,
    input  logic [63:0]         dest_value,
    input  logic [63:0]         src_value,
    input  logic signed [31:0]  dest_index,
    input  logic signed [31:0]  src_index,
    input  logic [63:0]         pp_ll,
    input  logic [31:0]         pp_lh,
    input  logic [31:0]         pp_hl,
    output logic [63:0]         result_value,
    output logic signed [31:0]  result_index
);
    import erau_pkg::*;

    logic [63:0] mask;
    logic [63:0] sbit;
    logic        sgn;
    logic [63:0] dm;
    logic [63:0] sm;
    logic [63:0] kd;
    logic [63:0] ks;
    logic [63:0] prod;
    logic [63:0] arith;
    logic        s_gt;
    logic        s_lt;
    logic        s_eq;
    logic        idx_lo;
    logic        bd;
    logic        bs;
    logic        loc_ok;
    logic        take_src;
    logic [3:0]  op_eff;

    // Width mask and sign bit for the integer types.
    always_comb
    begin
        case (cfg.ty[1:0])
            2'd0:
            begin
                mask = 64'h0000_0000_0000_00FF;
                sbit = 64'h0000_0000_0000_0080;
            end
            2'd1:
            begin
                mask = 64'h0000_0000_0000_FFFF;
                sbit = 64'h0000_0000_0000_8000;
            end
            2'd2:
            begin
                mask = 64'h0000_0000_FFFF_FFFF;
                sbit = 64'h0000_0000_8000_0000;
            end
            default:
            begin
                mask = 64'hFFFF_FFFF_FFFF_FFFF;
                sbit = 64'h8000_0000_0000_0000;
            end
        endcase
    end

    // Masked operands, order keys and comparisons.
    assign sgn    = !cfg.ty[2];
    assign dm     = dest_value & mask;
    assign sm     = src_value & mask;
    assign kd     = sgn ? (dm ^ sbit) : dm;
    assign ks     = sgn ? (sm ^ sbit) : sm;
    assign s_gt   = ks > kd;
    assign s_lt   = ks < kd;
    assign s_eq   = ks == kd;
    assign idx_lo = src_index < dest_index;
    assign bd     = dm != 64'd0;
    assign bs     = sm != 64'd0;

    // Low 64 bits of the product from the three partial products.
    assign prod = pp_ll + {pp_lh + pp_hl, 32'h0000_0000};

    // The index operators are only defined for the wide signed types.
    assign loc_ok = (cfg.ty == TY_S32) || (cfg.ty == TY_S64);

    always_comb
    begin
        op_eff = cfg.op;
        if (((cfg.op == OP_MAXLOC) || (cfg.op == OP_MINLOC)) && !loc_ok)
        begin
            op_eff = OP_SUM;
        end
    end

    // Integer operator selection.
    always_comb
    begin
        take_src = 1'b0;
        case (op_eff)
            OP_PROD:    arith = prod;
            OP_MAX:     arith = s_gt ? sm : dm;
            OP_MIN:     arith = s_lt ? sm : dm;
            OP_LAND:    arith = {63'd0, bd && bs};
            OP_BAND:    arith = dm & sm;
            OP_LOR:     arith = {63'd0, bd || bs};
            OP_BOR:     arith = dm | sm;
            OP_LXOR:    arith = {63'd0, bd != bs};
            OP_BXOR:    arith = dm ^ sm;
            OP_MAXLOC:
            begin
                take_src = s_gt || (s_eq && idx_lo);
                arith    = take_src ? sm : dm;
            end
            OP_MINLOC:
            begin
                take_src = s_lt || (s_eq && idx_lo);
                arith    = take_src ? sm : dm;
            end
            OP_REPLACE: arith = sm;
            default:    arith = dm + sm;
        endcase
    end

    // Final result: raw byte, opaque word or integer type.
    always_comb
    begin
        result_index = dest_index;
        if (cfg.ty == TY_RAW)
        begin
            case (cfg.op)
                OP_BAND:    result_value = {56'd0, dest_value[7:0] & src_value[7:0]};
                OP_BOR:     result_value = {56'd0, dest_value[7:0] | src_value[7:0]};
                OP_BXOR:    result_value = {56'd0, dest_value[7:0] ^ src_value[7:0]};
                OP_REPLACE: result_value = {56'd0, src_value[7:0]};
                default:    result_value = {56'd0, dest_value[7:0]};
            endcase
        end
        else if (cfg.ty > TY_RAW)
        begin
            result_value = (cfg.op == OP_REPLACE) ? src_value : dest_value;
        end
        else
        begin
            result_value = arith & mask;
            if (take_src)
            begin
                result_index = src_index;
            end
        end
    end

endmodule

>>> rtl/core/elementwise_reduction_alu_unit.sv
// ============================================================================
// Element-wise reduction ALU
// Streams pairs of elements through a configurable reduction operator.
// ============================================================================
// The unit accepts one element pair per cycle while in_stall is low and
// returns one result beat per pair. Each pair passes through the input stage
// and then the result register before its result is presented on the output.
// The input stage registers the operands together with three partial
// products of the 32-bit operand halves for the 64-bit multiply, and
// the second stage finishes the product, runs the compare and logic paths
// and loads the result register. Operator and element type are written
// through the APB port (operation at address 0, element type at address 4)
// and must only change while no beat is in flight.
module elementwise_reduction_alu_unit (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        dest_value,
    input  logic [63:0]        src_value,
    input  logic signed [31:0] dest_index,
    input  logic signed [31:0] src_index,
    input  logic               last_element,
    // Output channel.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [63:0]        result_value,
    output logic signed [31:0] result_index,
    output logic               result_last
);
    import erau_pkg::*;
    `include "elementwise_reduction_alu_unit_defines.svh"

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               cfg_wr;

    logic               a_valid_reg;
    logic               a_valid_next;
    logic [63:0]        a_dest_reg;
    logic [63:0]        a_src_reg;
    logic signed [31:0] a_didx_reg;
    logic signed [31:0] a_sidx_reg;
    logic               a_last_reg;
    logic [63:0]        a_pp_ll_reg;
    logic [31:0]        a_pp_lh_reg;
    logic [31:0]        a_pp_hl_reg;
    logic [63:0]        pp_ll_next;
    logic [31:0]        pp_lh_next;
    logic [31:0]        pp_hl_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [63:0]        res_value_reg;
    logic signed [31:0] res_index_reg;
    logic               res_last_reg;
    logic [63:0]        alu_value;
    logic signed [31:0] alu_index;

    logic               in_accept;
    logic               b_load;

    // Configuration registers; the port never waits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_OPERATION:    cfg_next.op = pwdata[3:0];
                REG_ELEMENT_TYPE: cfg_next.ty = pwdata[3:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op <= OP_SUM;
            cfg_reg.ty <= TY_S32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            REG_OPERATION:    prdata = {28'd0, cfg_reg.op};
            REG_ELEMENT_TYPE: prdata = {28'd0, cfg_reg.ty};
            default:          prdata = 32'd0;
        endcase
    end

    // Pipeline flow control: a stage advances when the one after it is
    // empty or is handing its beat on.
    assign b_load         = a_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = a_valid_reg && out_valid_reg && out_stall;
    assign in_accept      = in_valid && !in_stall;
    assign a_valid_next   = in_accept || (a_valid_reg && !b_load);
    assign out_valid_next = b_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Partial products of the low 64 bits of the 64-bit multiply.
    assign pp_ll_next = dest_value[31:0] * src_value[31:0];
    assign pp_lh_next = dest_value[31:0] * src_value[63:32];
    assign pp_hl_next = dest_value[63:32] * src_value[31:0];

    // Input stage.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_dest_reg  <= dest_value;
            a_src_reg   <= src_value;
            a_didx_reg  <= dest_index;
            a_sidx_reg  <= src_index;
            a_last_reg  <= last_element;
            a_pp_ll_reg <= pp_ll_next;
            a_pp_lh_reg <= pp_lh_next;
            a_pp_hl_reg <= pp_hl_next;
        end
    end

    // Operator datapath.
    erau_alu u_alu (
        .cfg          (cfg_reg),
        .dest_value   (a_dest_reg),
        .src_value    (a_src_reg),
        .dest_index   (a_didx_reg),
        .src_index    (a_sidx_reg),
        .pp_ll        (a_pp_ll_reg),
        .pp_lh        (a_pp_lh_reg),
        .pp_hl        (a_pp_hl_reg),
        .result_value (alu_value),
        .result_index (alu_index)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            res_value_reg <= alu_value;
            res_index_reg <= alu_index;
            res_last_reg  <= a_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = res_value_reg;
    assign result_index = res_index_reg;
    assign result_last  = res_last_reg;

    // Checks on the pipeline control and on the raw byte path.
    `ERAU_ASSERT_NOW(a_stall_full, in_stall, a_valid_reg && out_valid_reg,
        "input stalled while a pipeline stage is empty")
    `ERAU_ASSERT_NEXT(a_stage_moves, a_valid_reg && !(out_valid_reg && out_stall),
        out_valid_reg, "input stage beat did not reach the result register")
    `ERAU_ASSERT_NEXT(a_stage_holds, a_valid_reg && out_valid_reg && out_stall,
        a_valid_reg, "input stage beat lost while the output was stalled")
    `ERAU_ASSERT_NEXT(a_no_phantom, !a_valid_reg && !in_accept, !out_valid_reg || out_stall
        || !$rose(out_valid_reg), "result beat appeared with no beat in the input stage")
    `ERAU_ASSERT_NOW(a_raw_byte_width, out_valid_reg && (cfg_reg.ty == TY_RAW),
        result_value[63:8] == 56'd0, "raw byte result wider than one byte")

endmodule

>>> verif/erau_scoreboard_pkg.sv
// ============================================================================
// Element-wise reduction ALU scoreboard
// Keeps a copy of the operator and element type registers, works out the
// result beat for every accepted element pair, and checks the result beats
// in order.
// ============================================================================
package erau_scoreboard_pkg;

    import erau_pkg::*;

    // Byte addresses of the two configuration registers.
    localparam logic [2:0] ADDR_OPERATION    = {REG_OPERATION, 2'b00};
    localparam logic [2:0] ADDR_ELEMENT_TYPE = {REG_ELEMENT_TYPE, 2'b00};

    // One result beat as the block should present it.
    typedef struct {
        logic [63:0] value;
        logic [31:0] index;
        logic        last;
    } reduction_result_t;

    class reduction_scoreboard;

        logic [3:0]        op_reg;
        logic [3:0]        ty_reg;
        reduction_result_t expected_q[$];
        int                errors;

        function new();
            op_reg = OP_SUM;
            ty_reg = TY_S32;
            errors = 0;
        endfunction

        // Follow a write on the configuration port.
        function void register_write(logic [2:0] addr, logic [31:0] data);
            if (addr == ADDR_OPERATION)
                op_reg = data[3:0];
            else if (addr == ADDR_ELEMENT_TYPE)
                ty_reg = data[3:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Combine one destination and one source element under the current
        // operator and element type.
        function reduction_result_t combine(logic [63:0] dv, logic [63:0] sv,
                                            logic [31:0] di, logic [31:0] si,
                                            logic lst);
            reduction_result_t r;
            logic [3:0]  op;
            logic [1:0]  wsel;
            logic [63:0] mask, sbit, d, s, kd, ks, res;
            logic [31:0] kdi, ksi;
            logic        nzd, nzs, better;
            op      = op_reg;
            res     = dv;
            r.index = di;
            r.last  = lst;
            if (ty_reg == TY_RAW) begin
                // Raw bytes take only the bitwise operators and replace.
                d = dv & 64'hFF;
                s = sv & 64'hFF;
                case (op)
                    OP_BAND:    res = d & s;
                    OP_BOR:     res = d | s;
                    OP_BXOR:    res = d ^ s;
                    OP_REPLACE: res = s;
                    default:    res = d;
                endcase
            end else if (ty_reg > TY_RAW) begin
                // Unknown types are an opaque word.
                res = (op == OP_REPLACE) ? sv : dv;
            end else begin
                wsel = ty_reg[1:0];
                mask = (wsel == 2'd3) ? '1 : ((64'd1 << (32'd8 << wsel)) - 64'd1);
                sbit = 64'd1 << ((32'd8 << wsel) - 32'd1);
                d    = dv & mask;
                s    = sv & mask;
                // Flipping the sign bit turns a signed order into an unsigned one.
                kd   = (ty_reg < TY_U8) ? (d ^ sbit) : d;
                ks   = (ty_reg < TY_U8) ? (s ^ sbit) : s;
                nzd  = (d != 64'd0);
                nzs  = (s != 64'd0);
                // Index operators exist only for the wide signed types.
                if ((op == OP_MAXLOC || op == OP_MINLOC) &&
                    !(ty_reg == TY_S32 || ty_reg == TY_S64))
                    op = OP_SUM;
                case (op)
                    OP_PROD:    res = d * s;
                    OP_MAX:     res = (ks > kd) ? s : d;
                    OP_MIN:     res = (ks < kd) ? s : d;
                    OP_LAND:    res = (nzd && nzs) ? 64'd1 : 64'd0;
                    OP_BAND:    res = d & s;
                    OP_LOR:     res = (nzd || nzs) ? 64'd1 : 64'd0;
                    OP_BOR:     res = d | s;
                    OP_LXOR:    res = (nzd != nzs) ? 64'd1 : 64'd0;
                    OP_BXOR:    res = d ^ s;
                    OP_MAXLOC, OP_MINLOC:
                    begin
                        // Indices compare as signed; a tie goes to the lower one.
                        kdi    = di ^ 32'h8000_0000;
                        ksi    = si ^ 32'h8000_0000;
                        better = (op == OP_MAXLOC) ? (ks > kd) : (ks < kd);
                        if (better || (ks == kd && ksi < kdi))
                        begin
                            res     = s;
                            r.index = si;
                        end
                        else
                            res = d;
                    end
                    OP_REPLACE: res = s;
                    default:    res = d + s;
                endcase
                res = res & mask;
            end
            r.value = res;
            return r;
        endfunction

        // Note an accepted element pair.
        function void note_input(logic [63:0] dv, logic [63:0] sv,
                                 logic [31:0] di, logic [31:0] si, logic lst);
            expected_q.push_back(combine(dv, sv, di, si, lst));
        endfunction

        // Compare an accepted result beat with the oldest expected one.
        function void check_result(logic [63:0] v, logic [31:0] idx, logic lst,
                                   longint unsigned t);
            reduction_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0d ns: result beat with none expected: value %h index %h last %b",
                         t, v, idx, lst);
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.value)
            begin
                errors++;
                $display("%0d ns: result_value expected %h actual %h", t, e.value, v);
            end
            if (idx !== e.index)
            begin
                errors++;
                $display("%0d ns: result_index expected %h actual %h", t, e.index, idx);
            end
            if (lst !== e.last)
            begin
                errors++;
                $display("%0d ns: result_last expected %b actual %b", t, e.last, lst);
            end
        endfunction

    endclass

endpackage

>>> verif/testbench.sv
// ============================================================================
// Element-wise reduction ALU testbench
// Drives element pairs through every operator and element type, including
// undefined codes, with random gaps and output stalls, and checks every
// result beat against a scoreboard that predicts it.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import erau_pkg::*;
    import erau_scoreboard_pkg::*;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [2:0]         paddr        = '0;
    logic [31:0]        pwdata       = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [63:0]        dest_value   = '0;
    logic [63:0]        src_value    = '0;
    logic signed [31:0] dest_index   = '0;
    logic signed [31:0] src_index    = '0;
    logic               last_element = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [63:0]        result_value;
    logic signed [31:0] result_index;
    logic               result_last;

    reduction_scoreboard sb;
    logic [3:0]          cur_op     = OP_SUM;
    logic [3:0]          cur_ty     = TY_S32;
    bit                  quiet      = 1'b0;
    int                  stall_left = 0;

    elementwise_reduction_alu_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dest_value   (dest_value),
        .src_value    (src_value),
        .dest_index   (dest_index),
        .src_index    (src_index),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .result_index (result_index),
        .result_last  (result_last)
    );

    always #4 clk = ~clk;

    // Idle length: mostly none or short, now and then long, none in quiet phases.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Element values biased towards the corners of every width.
    function automatic logic [63:0] pick_value();
        int k;
        k = $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'd1 << k;
            3:       return ~(64'd1 << k);
            4:       return 64'($urandom_range(0, 3));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [31:0] pick_index();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            3:       return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // Output stalls of random length.
    always @(posedge clk)
    begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Watch both channels and the configuration port at every edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
                sb.register_write(paddr, pwdata);
            if (in_valid && !in_stall)
                sb.note_input(dest_value, src_value, dest_index, src_index, last_element);
            if (out_valid && !out_stall)
                sb.check_result(result_value, result_index, result_last, $time);
        end
    end

    // One input beat, after an optional gap; returns at the accepting edge.
    task automatic send_item(input logic [63:0] d, input logic [63:0] s,
                             input logic [31:0] di, input logic [31:0] si,
                             input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        dest_value   <= d;
        src_value    <= s;
        dest_index   <= di;
        src_index    <= si;
        last_element <= lst;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop sending and wait until every expected beat has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reconfigure once the pipeline is empty; upper data bits are junk.
    task automatic set_config(input logic [3:0] op, input logic [3:0] ty);
        drain_results();
        apb_write(ADDR_OPERATION, {28'($urandom()), op});
        apb_write(ADDR_ELEMENT_TYPE, {28'($urandom()), ty});
        cur_op = op;
        cur_ty = ty;
    endtask

    task automatic directed_beat(input logic [3:0] op, input logic [3:0] ty,
                                 input logic [63:0] d, input logic [63:0] s,
                                 input logic [31:0] di, input logic [31:0] si,
                                 input logic lst);
        if (op != cur_op || ty != cur_ty)
            set_config(op, ty);
        send_item(d, s, di, si, lst);
    endtask

    initial
    begin
        int          sent;
        int          n;
        logic [63:0] d, s;
        logic [31:0] di, si;
        logic [3:0]  op, ty;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: signed 32-bit sum wrapping round.
        directed_beat(OP_SUM, TY_S32, '1, 64'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        directed_beat(OP_SUM, TY_S32, 64'h7FFF_FFFF, 64'd1, 32'd0, '1, 1'b0);
        // Each operator in turn, with signed and unsigned comparisons.
        directed_beat(OP_PROD, TY_U64, '1, '1, 32'd3, 32'd4, 1'b0);
        directed_beat(OP_MAX, TY_S8, 64'h7F, 64'h80, 32'd1, 32'd2, 1'b0);
        directed_beat(OP_MAX, TY_U8, 64'h7F, 64'h80, 32'd1, 32'd2, 1'b1);
        directed_beat(OP_MIN, TY_S16, 64'h1, 64'h8000, 32'd5, 32'd6, 1'b0);
        directed_beat(OP_LAND, TY_S32, 64'h1_0000_0000, 64'd5, 32'd0, 32'd0, 1'b0);
        directed_beat(OP_BAND, TY_U32, 64'hDEAD_BEEF_F0F0_FFFF, '1, 32'd9, 32'd8, 1'b0);
        directed_beat(OP_LOR, TY_U16, 64'hFFFF_0000, 64'd0, 32'd0, 32'd1, 1'b0);
        directed_beat(OP_BOR, TY_S64, 64'h8000_0000_0000_0000, 64'd1, 32'd2, 32'd1, 1'b1);
        directed_beat(OP_LXOR, TY_U8, 64'h100, 64'd3, 32'd0, 32'd0, 1'b0);
        directed_beat(OP_BXOR, TY_S32, '1, 64'h5555_5555_5555_5555, 32'd0, 32'd0, 1'b0);
        // Index operators: a tie picks the lower index.
        directed_beat(OP_MAXLOC, TY_S32, 64'd5, 64'd5, 32'd7, 32'hFFFF_FFFD, 1'b0);
        directed_beat(OP_MINLOC, TY_S32, 64'd5, 64'd5, 32'h8000_0000, 32'd7, 1'b0);
        directed_beat(OP_MINLOC, TY_S64, 64'd1, '1, 32'd7, 32'd9, 1'b1);
        // Index operators on a narrow type act as sum.
        directed_beat(OP_MAXLOC, TY_U16, 64'hFFFF, 64'd2, 32'd1, 32'd0, 1'b0);
        directed_beat(OP_REPLACE, TY_S8, 64'h12, 64'hFFFF_FFFF_FFFF_FF81, 32'd0, 32'd1, 1'b0);
        // Raw bytes: logical operators keep the destination byte; bitwise operators and replace act on the low byte.
        directed_beat(OP_LAND, TY_RAW, 64'hABCD, 64'h12, 32'd4, 32'd5, 1'b0);
        directed_beat(OP_BXOR, TY_RAW, 64'h1FF, 64'h0F, 32'd4, 32'd5, 1'b0);
        directed_beat(OP_REPLACE, TY_RAW, 64'h11, 64'hFF80, 32'd4, 32'd5, 1'b1);
        // Undefined operator codes sum; undefined types are an opaque word.
        directed_beat(4'd15, TY_U32, 64'hFFFF_FFFF, 64'd2, 32'd0, 32'd0, 1'b0);
        directed_beat(OP_REPLACE, 4'd12, 64'd1, '1, 32'd0, 32'd1, 1'b0);
        directed_beat(OP_PROD, 4'd9, 64'h0123_4567_89AB_CDEF, 64'd3, 32'd2, 32'd3, 1'b1);

        // Random phases, each with its own configuration.
        sent = 0;
        while (sent < 1650)
        begin
            n  = $urandom_range(10, 80);
            op = ($urandom_range(0, 19) < 18) ? 4'($urandom_range(0, 12))
                                              : 4'($urandom_range(13, 15));
            ty = ($urandom_range(0, 19) < 17) ? 4'($urandom_range(0, 8))
                                              : 4'($urandom_range(9, 15));
            set_config(op, ty);
            quiet = ($urandom_range(0, 4) == 0);
            repeat (n)
            begin
                d = pick_value();
                // Equal values, also equal only in the low half, exercise ties.
                case ($urandom_range(0, 7))
                    0:       s = d;
                    1:       s = d ^ {$urandom(), 32'd0};
                    default: s = pick_value();
                endcase
                di = pick_index();
                si = ($urandom_range(0, 5) == 0) ? di : pick_index();
                send_item(d, s, di, si, 1'($urandom_range(0, 1)));
            end
            sent += n;
        end

        drain_results();
        quiet = 1'b0;
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Give up if the run hangs.
    initial
    begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
